### hw/rtl/dequ_pkg.sv
// Shared types and constants for the double-ended queue unit.
// No dependencies; imported by every module of the block.
package dequ_pkg;

	localparam int WORD_W   = 32;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_PUSH_REAR  = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_REAR   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_LOAD = 1'b1
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;   // carry out the accepted request on the ring
		logic load;   // move the finished result into the output register
	} dequ_cmd_t;

endpackage

### hw/rtl/dequ_ctrl.sv
// Controller of the double-ended queue unit: request and response handshakes.
// Depends on dequ_pkg; drives dequ_datapath through dequ_cmd_t.
module dequ_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dequ_pkg::dequ_cmd_t cmd
);
	import dequ_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        rsp_valid_q, rsp_valid_d;
	logic        out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (req_valid) begin
					state_d = CS_LOAD;
				end
			end
			CS_LOAD: begin
				if (out_free) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		req_stall   = 1'b1;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		unique case (state_q)
			CS_IDLE: begin
				req_stall = 1'b0;
				cmd.exec  = req_valid;
			end
			CS_LOAD: begin
				// hold the result until the output register frees up
				cmd.load = out_free;
				if (out_free) begin
					rsp_valid_d = 1'b1;
				end
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### hw/rtl/dequ_datapath.sv
// Datapath of the double-ended queue unit: ring memory, pointers, output register.
// Depends on dequ_pkg; commanded by dequ_ctrl.
module dequ_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dequ_pkg::dequ_cmd_t                   cmd,
	input  logic [dequ_pkg::MODE_W-1:0]           mode,
	input  logic signed [dequ_pkg::WORD_W-1:0]    push_value,
	output logic signed [dequ_pkg::WORD_W-1:0]    pop_value,
	output logic [dequ_pkg::STATUS_W-1:0]         status,
	output logic [dequ_pkg::FILL_W-1:0]           fill_count
);
	import dequ_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;

	logic [WORD_W-1:0] ring_mem [DEPTH];

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	stat_t         stat_q, stat_d;
	logic          pop_ok_q, pop_ok_d;
	logic [WORD_W-1:0] rd_data_q;

	logic signed [WORD_W-1:0] pop_value_q;
	stat_t                    status_q;
	logic [FILL_W-1:0]        fill_q;

	logic          full, empty;
	logic [AW-1:0] front_dec, front_inc, rear_push, rear_pop;
	logic [SW-1:0] end_sum, end_sum_m1;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          wr_en, rd_en;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	// ring positions: front +/- 1 and front + count (- 1), wrapped mod DEPTH
	assign front_dec  = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc  = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign end_sum    = SW'(front_q) + SW'(count_q);
	assign end_sum_m1 = end_sum - SW'(1);
	assign rear_push  = (end_sum >= SW'(DEPTH)) ? AW'(end_sum - SW'(DEPTH)) : AW'(end_sum);
	assign rear_pop   = (end_sum_m1 >= SW'(DEPTH)) ? AW'(end_sum_m1 - SW'(DEPTH))
	                                               : AW'(end_sum_m1);

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		stat_d   = stat_q;
		pop_ok_d = pop_ok_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = rear_push;
		rd_addr  = front_q;
		if (cmd.exec) begin
			stat_d   = STAT_OK;
			pop_ok_d = 1'b0;
			unique case (mode_t'(mode))
				MODE_PUSH_FRONT: begin
					if (full) begin
						stat_d = STAT_FULL;
					end else begin
						wr_en   = 1'b1;
						wr_addr = front_dec;
						front_d = front_dec;
						count_d = count_q + CW'(1);
					end
				end
				MODE_PUSH_REAR: begin
					if (full) begin
						stat_d = STAT_FULL;
					end else begin
						wr_en   = 1'b1;
						wr_addr = rear_push;
						count_d = count_q + CW'(1);
					end
				end
				MODE_POP_FRONT: begin
					if (empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						rd_en    = 1'b1;
						pop_ok_d = 1'b1;
						rd_addr  = front_q;
						front_d  = front_inc;
						count_d  = count_q - CW'(1);
					end
				end
				MODE_POP_REAR: begin
					if (empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						rd_en    = 1'b1;
						pop_ok_d = 1'b1;
						rd_addr  = rear_pop;
						count_d  = count_q - CW'(1);
					end
				end
				default: stat_d = STAT_OK;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= push_value;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			stat_q   <= STAT_OK;
			pop_ok_q <= 1'b0;
		end else begin
			front_q  <= front_d;
			count_q  <= count_d;
			stat_q   <= stat_d;
			pop_ok_q <= pop_ok_d;
		end
	end

	// output register; count_q already reflects the finished request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pop_value_q <= pop_ok_q ? $signed(rd_data_q) : '0;
			status_q    <= stat_q;
			fill_q      <= FILL_W'(count_q);
		end
	end

	assign pop_value  = pop_value_q;
	assign status     = status_q;
	assign fill_count = fill_q;

endmodule

### hw/rtl/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// Each request pushes or pops at the front or the rear and yields one response
// with the popped word (zero unless a pop succeeds), a status (ok, pop on empty,
// push on full) and the entry count after the request, truncated to 5 bits.
// A request first moves the pointers and writes or reads the ring memory, then
// loads the output register from the memory's registered read port. A new
// request is taken while an earlier response still waits to be taken; it then
// waits in the load state until the output register frees up.
// Depends on dequ_pkg, dequ_ctrl and dequ_datapath.
module double_ended_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic [dequ_pkg::MODE_W-1:0]           mode,
	input  logic signed [dequ_pkg::WORD_W-1:0]    push_value,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output logic signed [dequ_pkg::WORD_W-1:0]    pop_value,
	output logic [dequ_pkg::STATUS_W-1:0]         status,
	output logic [dequ_pkg::FILL_W-1:0]           fill_count
);
	import dequ_pkg::*;

	dequ_cmd_t cmd;

	dequ_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	dequ_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.push_value (push_value),
		.pop_value  (pop_value),
		.status     (status),
		.fill_count (fill_count)
	);

endmodule

### hw/rtl/dequ_checker.sv
// Port-level checks for the double-ended queue unit, bound to the top level.
// Depends on dequ_pkg and double_ended_queue_unit.
module dequ_checker #(
	parameter int DEPTH = 16
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  req_valid,
	input logic                                  req_stall,
	input logic                                  rsp_valid,
	input logic                                  rsp_stall,
	input logic signed [dequ_pkg::WORD_W-1:0]    pop_value,
	input logic [dequ_pkg::STATUS_W-1:0]         status,
	input logic [dequ_pkg::FILL_W-1:0]           fill_count
);
	import dequ_pkg::*;

	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(pop_value) &&
			$stable(status) && $stable(fill_count))
		else $error("stalled response changed");

	// a failed pop reports an empty deque and no word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_EMPTY) |-> (fill_count == '0) && (pop_value == '0))
		else $error("empty status with nonzero count or word");

	// a refused push reports a full deque and no word
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == STAT_FULL) |-> (fill_count == FULL_FILL) && (pop_value == '0))
		else $error("full status with wrong count or nonzero word");

	// an idle cycle that takes no request and shows no response is followed by no response
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid && !req_stall && !(req_valid && !req_stall) |=> !rsp_valid)
		else $error("response without a request");

endmodule

bind double_ended_queue_unit dequ_checker #(.DEPTH(DEPTH)) u_dequ_checker (.*);
